/* design/fifo_replacement_kv_cache_macros.svh */
// Assertion macros shared by the key/value store RTL.
`ifndef FIFO_REPLACEMENT_KV_CACHE_MACROS_SVH
`define FIFO_REPLACEMENT_KV_CACHE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FRKV_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Property whose consequent must hold in the clock cycle after the antecedent.
`define FRKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/frkv_pkg.sv */
// Package with the types and constants of the key/value store.
package frkv_pkg;

   localparam int ENTRIES    = 4;
   localparam int KEY_BITS   = 32;
   localparam int AGE_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      CMD_PUT        = 2'd0,
      CMD_GET        = 2'd1,
      CMD_REM_OLDEST = 2'd2,
      CMD_REM_KEY    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_EVICT = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        key;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] read_value;
   } rsp_item_type;

endpackage

/* design/fifo_replacement_kv_cache.sv */
// Top level of the fully associative key/value store with FIFO replacement.
//
// Usage: every request item carries one command (put, get, remove oldest or
// remove by key) with a key and a value, and produces exactly one response
// item holding a status code and, for a get hit, the stored value.
// Both channels use valid and stall; an item moves on a rising edge at which
// valid is high and stall is low.
// Path: a request accepted into the input register is processed from there
// into the result register, from which its response is offered until the
// receiver takes it.
// Throughput: one item per cycle while no stall holds the flow. The key compare
// across all entries, the age update and the result are done in one pass of
// logic between the input and result registers.
// Stalls: when the receiver stalls a waiting response, the input register
// holds its item and req_stall rises once that register is occupied.
// Reset: synchronous, active high; it empties the store, drops any items
// in flight and clears all ages and the entry count. Key and value storage
// is not cleared, as it is only read through valid entries.
`include "fifo_replacement_kv_cache_macros.svh"

module fifo_replacement_kv_cache import frkv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // Input register.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // Result register.
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   // Store.
   logic [KEY_BITS-1:0] slot_key_ff   [ENTRIES];
   logic [KEY_BITS-1:0] slot_key_in   [ENTRIES];
   logic [31:0]         slot_value_ff [ENTRIES];
   logic [31:0]         slot_value_in [ENTRIES];
   logic [ENTRIES-1:0]  slot_valid_ff, slot_valid_in;
   logic [AGE_BITS-1:0] slot_age_ff   [ENTRIES];
   logic [AGE_BITS-1:0] slot_age_in   [ENTRIES];
   logic [COUNT_BITS-1:0] entry_count_ff, entry_count_in;

   // Lookup and decision signals.
   logic                  advance;
   logic                  fire;
   logic [KEY_BITS-1:0]   cmp_key;
   logic [ENTRIES-1:0]    hit_vec;
   logic [ENTRIES-1:0]    old_vec;
   logic [ENTRIES-1:0]    free_vec;
   logic [ENTRIES-1:0]    drop_vec;
   logic [ENTRIES-1:0]    ins_vec;
   logic [ENTRIES-1:0]    upd_vec;
   logic                  any_hit;
   logic                  store_full;
   logic                  store_empty;
   logic                  free_found;
   logic [31:0]           hit_value;
   logic [AGE_BITS-1:0]   drop_age;
   logic [COUNT_BITS-1:0] count_after_drop;
   status_type            status;
   logic [31:0]           read_value;

   // The processing stage moves on when the result register is free or is
   // being emptied in this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   assign cmp_key     = in_item_ff.key[KEY_BITS-1:0];
   assign store_full  = (entry_count_ff == COUNT_BITS'(ENTRIES));
   assign store_empty = (entry_count_ff == '0);
   assign any_hit     = |hit_vec;

   // Parallel compare against every entry. Keys are unique in the store, so
   // at most one entry hits, and while the store is not empty the ages keep exactly one entry oldest.
   always_comb begin
      hit_value  = '0;
      free_vec   = '0;
      free_found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = slot_valid_ff[i] && (slot_key_ff[i] == cmp_key);
         old_vec[i] = slot_valid_ff[i] && (slot_age_ff[i] == '0);
         if (hit_vec[i]) begin
            hit_value = hit_value | slot_value_ff[i];
         end
         // Lowest free slot takes a new entry.
         if (!slot_valid_ff[i] && !free_found) begin
            free_vec[i] = 1'b1;
            free_found  = 1'b1;
         end
      end
   end

   // Command decode: which slots are dropped, filled or updated.
   always_comb begin
      drop_vec   = '0;
      ins_vec    = '0;
      upd_vec    = '0;
      status     = ST_OK;
      read_value = '0;
      case (in_item_ff.cmd)
         CMD_PUT: begin
            if (any_hit) begin
               upd_vec = hit_vec;
            end else if (store_full) begin
               // The oldest entry leaves and the new pair takes its slot.
               drop_vec = old_vec;
               ins_vec  = old_vec;
               status   = ST_EVICT;
            end else begin
               ins_vec = free_vec;
            end
         end
         CMD_GET: begin
            if (any_hit) begin
               read_value = hit_value;
            end else begin
               status = ST_MISS;
            end
         end
         CMD_REM_OLDEST: begin
            if (store_empty || !(|old_vec)) begin
               status = ST_EMPTY;
            end else begin
               drop_vec = old_vec;
            end
         end
         CMD_REM_KEY: begin
            if (store_empty) begin
               status = ST_EMPTY;
            end else if (any_hit) begin
               drop_vec = hit_vec;
            end else begin
               status = ST_MISS;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // Age of the dropped entry; younger entries close the gap behind it.
   always_comb begin
      drop_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (drop_vec[i]) begin
            drop_age = drop_age | slot_age_ff[i];
         end
      end
   end

   assign count_after_drop = entry_count_ff - COUNT_BITS'(|drop_vec);

   // Next state of the store.
   always_comb begin
      entry_count_in = entry_count_ff;
      slot_valid_in  = slot_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key_in[i]   = slot_key_ff[i];
         slot_value_in[i] = slot_value_ff[i];
         slot_age_in[i]   = slot_age_ff[i];
      end
      if (fire) begin
         entry_count_in = count_after_drop + COUNT_BITS'(|ins_vec);
         for (int i = 0; i < ENTRIES; i++) begin
            if (ins_vec[i]) begin
               // New entry is the youngest of what remains.
               slot_key_in[i]   = cmp_key;
               slot_value_in[i] = in_item_ff.value;
               slot_valid_in[i] = 1'b1;
               slot_age_in[i]   = count_after_drop[AGE_BITS-1:0];
            end else if (drop_vec[i]) begin
               slot_valid_in[i] = 1'b0;
               slot_age_in[i]   = '0;
            end else begin
               if (upd_vec[i]) begin
                  slot_value_in[i] = in_item_ff.value;
               end
               if (slot_valid_ff[i] && (|drop_vec) && (slot_age_ff[i] > drop_age)) begin
                  slot_age_in[i] = slot_age_ff[i] - AGE_BITS'(1);
               end
            end
         end
      end
   end

   // Handshake of the two registers.
   always_comb begin
      in_item_in = in_item_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      out_item_in = out_item_ff;
      if (fire) begin
         out_valid_in           = 1'b1;
         out_item_in.status     = status;
         out_item_in.read_value = read_value;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         slot_valid_ff  <= '0;
         entry_count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_age_ff[i] <= '0;
         end
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         slot_valid_ff  <= slot_valid_in;
         entry_count_ff <= entry_count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_age_ff[i] <= slot_age_in[i];
         end
      end
   end

   // Payload state, not reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key_ff[i]   <= slot_key_in[i];
         slot_value_ff[i] <= slot_value_in[i];
      end
   end

   `FRKV_ASSERT_ALWAYS(a_count_bound, entry_count_ff <= COUNT_BITS'(ENTRIES), "entry count too large")
   `FRKV_ASSERT_ALWAYS(a_count_matches, $countones(slot_valid_ff) == int'(entry_count_ff), "entry count differs from valid entries")
   `FRKV_ASSERT_ALWAYS(a_unique_hit, $onehot0(hit_vec), "key held in more than one entry")
   `FRKV_ASSERT_NEXT(a_result_loaded, fire, out_valid_ff, "processed item left no result")

endmodule

/* tb/fifo_replacement_kv_cache_tb.sv */
// Self-checking testbench for the FIFO-replacement key/value store.
module fifo_replacement_kv_cache_tb import frkv_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Only the low KEY_BITS of a key take part in compares and storage.
   localparam logic [31:0] KEY_MASK   = 32'hFFFF_FFFF >> (32 - KEY_BITS);
   localparam int          RANDOM_CMDS = 2000;
   localparam int          IDLE_PCT    = 10;
   localparam int          HOLD_CYCLES = 300;
   localparam int          POOL_SIZE   = 6;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   fifo_replacement_kv_cache DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   // A row of the directed table. Where checked_by_hand is set, the expected
   // result is typed into the row; otherwise the predictor supplies it.
   typedef struct {
      req_item_type cmd_item;
      bit           checked_by_hand;
      rsp_item_type result;
   } directed_row_type;

   directed_row_type directed_rows[$];
   rsp_item_type     pending_results[$];
   int               error_count  = 0;
   bit               quiet_phase  = 1'b0;
   bit               hold_request = 1'b0;
   int               hold_left    = 0;

   // Predictor's own copy of the store. Slot keys and values are only ever
   // read through a valid slot, just as in the block.
   logic [31:0]        store_key   [ENTRIES];
   logic signed [31:0] store_value [ENTRIES];
   bit                 store_used  [ENTRIES];
   int unsigned        store_age   [ENTRIES];
   int unsigned        store_count = 0;

   // The oldest valid slot is the one whose age is zero.
   function automatic int oldest_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (store_used[i] && store_age[i] == 0) return i;
      return -1;
   endfunction

   // Freeing a slot closes the gap: every younger entry moves one place
   // towards the oldest end.
   function automatic void drop_entry(int slot);
      int unsigned gap_age;
      gap_age = store_age[slot];
      store_used[slot] = 1'b0;
      store_age[slot]  = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (store_used[i] && store_age[i] > gap_age) store_age[i]--;
      if (store_count > 0) store_count--;
   endfunction

   // Applies one command to the predictor's store and returns the result
   // that the block must produce for it.
   function automatic rsp_item_type kv_result(req_item_type cmd_item);
      rsp_item_type outcome;
      logic [31:0]  k;
      int           hit;
      int           slot;
      outcome.status     = ST_OK;
      outcome.read_value = '0;
      k   = cmd_item.key & KEY_MASK;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && store_used[i] && store_key[i] == k) hit = i;
      case (cmd_item.cmd)
         CMD_PUT: begin
            if (hit >= 0) begin
               // Update in place; the entry keeps its position in the order.
               store_value[hit] = cmd_item.value;
            end else begin
               if (store_count >= ENTRIES) begin
                  slot = oldest_slot();
                  if (slot >= 0) drop_entry(slot);
                  outcome.status = ST_EVICT;
               end
               slot = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && !store_used[i]) slot = i;
               if (slot >= 0) begin
                  store_key[slot]   = k;
                  store_value[slot] = cmd_item.value;
                  store_used[slot]  = 1'b1;
                  store_age[slot]   = store_count;
                  store_count++;
               end
            end
         end
         CMD_GET: begin
            if (hit >= 0) outcome.read_value = store_value[hit];
            else outcome.status = ST_MISS;
         end
         CMD_REM_OLDEST: begin
            slot = oldest_slot();
            if (store_count == 0 || slot < 0) outcome.status = ST_EMPTY;
            else drop_entry(slot);
         end
         default: begin
            if (store_count == 0) outcome.status = ST_EMPTY;
            else if (hit >= 0) drop_entry(hit);
            else outcome.status = ST_MISS;
         end
      endcase
      return outcome;
   endfunction

   task automatic add_row(cmd_type cmd, logic [31:0] key, logic signed [31:0] value,
                          bit checked_by_hand, status_type status,
                          logic signed [31:0] read_value);
      directed_row_type row;
      row.cmd_item.cmd        = cmd;
      row.cmd_item.key        = key;
      row.cmd_item.value      = value;
      row.checked_by_hand     = checked_by_hand;
      row.result.status       = status;
      row.result.read_value   = read_value;
      directed_rows.push_back(row);
   endtask

   // Offers one item, with random idle cycles in front of it outside the quiet
   // phase, and waits until the block takes it. The expectation is queued at
   // the very edge of acceptance, so the store order matches the block's.
   task automatic offer_command(req_item_type cmd_item, bit checked_by_hand,
                                rsp_item_type typed_result);
      rsp_item_type predicted;
      while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= cmd_item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The predictor runs on every item, so its store stays in step even
      // where the row carries its own expected result.
      predicted = kv_result(cmd_item);
      pending_results.push_back(checked_by_hand ? typed_result : predicted);
   endtask

   // Receiver: checks every accepted result against the oldest expectation
   // and decides its stall for the next cycle. A long hold, once asked for
   // by the sender, is counted down here so that the block fills up and
   // raises req_stall while the sender keeps offering.
   always @(posedge clock) begin
      rsp_item_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result item with no expectation waiting: status %0d, read_value %0d",
                   rsp_item.status, rsp_item.read_value);
            error_count++;
         end else begin
            wanted = pending_results[0];
            pending_results.delete(0);
            if (rsp_item.status !== wanted.status) begin
               $error("status: expected %0d, actual %0d", wanted.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.read_value !== wanted.read_value) begin
               $error("read_value: expected %0d, actual %0d",
                      wanted.read_value, rsp_item.read_value);
               error_count++;
            end
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [31:0]  key_pool [POOL_SIZE];
      req_item_type cmd_item;
      rsp_item_type no_result;
      int           pick;
      no_result = '0;

      // Directed part. The early rows run on an empty store straight after
      // reset, then the store is filled to the point of eviction, and
      // entries are removed from the middle and from the oldest end.
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        1, ST_EMPTY, 32'sd0);
      add_row(CMD_REM_KEY,    32'hFFFF_FFFF, 32'sd0,        1, ST_EMPTY, 32'sd0);
      add_row(CMD_GET,        32'h0000_0000, 32'sd0,        1, ST_MISS,  32'sd0);
      add_row(CMD_PUT,        32'h0000_0000, 32'h8000_0000, 1, ST_OK,    32'sd0);
      add_row(CMD_GET,        32'h0000_0000, 32'h7FFF_FFFF, 1, ST_OK,    32'h8000_0000);
      add_row(CMD_PUT,        32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, ST_OK,    32'sd0);
      add_row(CMD_GET,        32'hFFFF_FFFF, 32'sd0,        1, ST_OK,    32'h7FFF_FFFF);
      // A put that hits replaces the value but keeps the entry's age.
      add_row(CMD_PUT,        32'h0000_0000, -32'sd1,       1, ST_OK,    32'sd0);
      add_row(CMD_GET,        32'h0000_0000, 32'sd0,        1, ST_OK,    -32'sd1);
      add_row(CMD_PUT,        32'hAAAA_AAAA, 32'h5555_5555, 0, ST_OK,    32'sd0);
      add_row(CMD_PUT,        32'h5555_5555, 32'hAAAA_AAAA, 0, ST_OK,    32'sd0);
      // The store is full now, so a new key pushes out the oldest entry.
      add_row(CMD_PUT,        32'h1234_5678, 32'sd1,        1, ST_EVICT, 32'sd0);
      add_row(CMD_GET,        32'h0000_0000, 32'sd0,        1, ST_MISS,  32'sd0);
      add_row(CMD_GET,        32'hFFFF_FFFF, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_KEY,    32'hDEAD_BEEF, 32'sd0,        1, ST_MISS,  32'sd0);
      add_row(CMD_REM_KEY,    32'hAAAA_AAAA, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_GET,        32'hFFFF_FFFF, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_PUT,        32'h0000_0000, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_GET,        32'h5555_5555, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        0, ST_OK,    32'sd0);
      add_row(CMD_REM_OLDEST, 32'h0000_0000, 32'sd0,        1, ST_EMPTY, 32'sd0);
      add_row(CMD_REM_KEY,    32'h0000_0000, 32'sd0,        1, ST_EMPTY, 32'sd0);

      for (int i = 0; i < ENTRIES; i++) store_used[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_command(directed_rows[i].cmd_item, directed_rows[i].checked_by_hand,
                       directed_rows[i].result);

      // Random part. Most keys come from a small pool a little larger than
      // the store, so hits, misses, in-place updates and evictions all occur
      // often; a tenth of the keys are wholly random noise. The pool is
      // refreshed now and then so that every key bit is exercised.
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 200 == 199) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         quiet_phase = (n >= 1000 && n < 1300);
         if (n == 500) hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 40)      cmd_item.cmd = CMD_PUT;
         else if (pick < 70) cmd_item.cmd = CMD_GET;
         else if (pick < 82) cmd_item.cmd = CMD_REM_OLDEST;
         else                cmd_item.cmd = CMD_REM_KEY;
         cmd_item.key   = ($urandom_range(0, 99) < 10) ? $urandom
                                                       : key_pool[$urandom_range(0, POOL_SIZE - 1)];
         cmd_item.value = $urandom;
         offer_command(cmd_item, 1'b0, no_result);
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;

      // Drain: wait for every outstanding result, then idle on so that any
      // stray result arriving late would still be caught.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, including the long hold.
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
